### sv/quad_to_unit_square_point_map_unit_macros.svh
// Assertion macros for the quad-to-unit-square point map.
// Included by modules that check their own pipeline; expects i_clk and i_rst_n in scope.
`ifndef QUAD_TO_UNIT_SQUARE_POINT_MAP_UNIT_MACROS_SVH
`define QUAD_TO_UNIT_SQUARE_POINT_MAP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define Q2US_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define Q2US_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

### sv/q2us_pkg.sv
// Shared widths, latencies and register codes for the quad-to-unit-square point map.
// No dependencies; imported by q2us_div and the top level.
package q2us_pkg;

    localparam int unsigned COORD_BITS = 10;
    localparam int unsigned FRAC_BITS  = 14;
    localparam int unsigned OUT_W      = 18;

    // coordinate differences, rotated coordinates, sheared values
    localparam int unsigned DIFF_W   = COORD_BITS + 1;
    localparam int unsigned ROT_W    = 2 * COORD_BITS + 2;
    localparam int unsigned SHR_W    = 2 * ROT_W + 2;
    localparam int unsigned HALF_W   = SHR_W / 2;
    localparam int unsigned PP_LO_W  = ROT_W + HALF_W + 1;
    localparam int unsigned PP_HI_W  = ROT_W + SHR_W - HALF_W;
    localparam int unsigned PROD_W   = ROT_W + SHR_W;
    localparam int unsigned NUM_W    = PROD_W;
    localparam int unsigned NUM_PROD = 6;

    // divider widths
    localparam int unsigned MAG_W = NUM_W - 1;
    localparam int unsigned REM_W = MAG_W + FRAC_BITS + 2;
    localparam int unsigned DEN_W = MAG_W + 1;
    localparam int unsigned CMP_W = DEN_W + OUT_W;

    // latencies in cycles
    localparam int unsigned DIV_LAT   = OUT_W + 2;
    localparam int unsigned FRONT_LAT = 6;
    localparam int unsigned PIPE_LAT  = FRONT_LAT + DIV_LAT + 1;

    localparam int unsigned CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_X = 4'd0,
        CFG_A_Y = 4'd1,
        CFG_B_X = 4'd2,
        CFG_B_Y = 4'd3,
        CFG_C_X = 4'd4,
        CFG_C_Y = 4'd5,
        CFG_D_X = 4'd6,
        CFG_D_Y = 4'd7
    } t_cfg_reg;

    localparam logic [COORD_BITS-1:0] COORD_MIN = '0;
    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

endpackage

### sv/q2us_div.sv
// Pipelined rounding divider: n/d to FRAC_BITS, ties away from zero, saturated.
// Depends on q2us_pkg; one quotient bit per stage.
module q2us_div import q2us_pkg::*; (
    input  logic                    i_clk,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [NUM_W-1:0] i_den,
    output logic signed [OUT_W-1:0] o_quo
);

    logic [REM_W-1:0] r_rem [OUT_W+1];
    logic [DEN_W-1:0] r_den [OUT_W+1];
    logic [OUT_W-1:0] r_quo [OUT_W+1];
    logic             r_neg [OUT_W+1];
    logic             r_ovf [OUT_W+1];

    logic [MAG_W-1:0] mag_n;
    logic [MAG_W-1:0] mag_d;
    logic [REM_W-1:0] n_rem0;
    logic [DEN_W-1:0] n_den0;
    logic             n_ovf0;

    // take magnitudes, fold in the rounding half, flag quotients that cannot fit
    always_comb begin
        mag_n  = i_num[NUM_W-1] ? MAG_W'(-i_num) : MAG_W'(i_num);
        mag_d  = i_den[NUM_W-1] ? MAG_W'(-i_den) : MAG_W'(i_den);
        n_rem0 = (REM_W'(mag_n) << (FRAC_BITS + 1)) + REM_W'(mag_d);
        n_den0 = {mag_d, 1'b0};
        n_ovf0 = CMP_W'(n_rem0) >= {n_den0, {OUT_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_rem0;
        r_den[0] <= n_den0;
        r_quo[0] <= '0;
        r_neg[0] <= i_num[NUM_W-1] ^ i_den[NUM_W-1];
        r_ovf[0] <= n_ovf0;
    end

    // restoring steps, most significant quotient bit first
    for (genvar j = 0; j < OUT_W; j++) begin : gen_step
        localparam int unsigned K = OUT_W - 1 - j;
        logic [CMP_W-1:0] trial;
        logic             take;
        logic [REM_W-1:0] n_rem;

        always_comb begin
            trial = CMP_W'(r_den[j]) << K;
            take  = CMP_W'(r_rem[j]) >= trial;
            n_rem = take ? r_rem[j] - REM_W'(trial) : r_rem[j];
        end

        always_ff @(posedge i_clk) begin
            r_rem[j+1] <= n_rem;
            r_den[j+1] <= r_den[j];
            r_quo[j+1] <= r_quo[j] | (take ? (OUT_W'(1) << K) : '0);
            r_neg[j+1] <= r_neg[j];
            r_ovf[j+1] <= r_ovf[j];
        end
    end

    logic [OUT_W-1:0] lim;
    logic [OUT_W-1:0] q0;

    // clamp to the signed range and apply the sign
    always_comb begin
        lim = r_neg[OUT_W] ? (OUT_W'(1) << (OUT_W - 1)) : {1'b0, {(OUT_W-1){1'b1}}};
        q0  = (r_ovf[OUT_W] || (r_quo[OUT_W] > lim)) ? lim : r_quo[OUT_W];
    end

    always_ff @(posedge i_clk) begin
        o_quo <= r_neg[OUT_W] ? -$signed(q0) : $signed(q0);
    end

endmodule

### sv/quad_to_unit_square_point_map_unit.sv
// Top level of the quad-to-unit-square point map: corner registers, front pipeline, dividers.
// Depends on q2us_pkg, q2us_div and the assertion macro header.
//
// Usage:
//   Write the eight corner registers (A, B, C, D; x then y, index 0..7) through
//   i_cfg_valid / i_cfg_index / i_cfg_data; o_cfg_ready is always high and
//   indexes above 7 are ignored. Write them only while no point is in flight.
//   Present a camera point on i_pt_x / i_pt_y with start high; busy is always
//   low, so a point is taken on every cycle that start is high.
//   Each point gives one word on o_out_u / o_out_v / o_degenerate, marked by
//   o_valid for one cycle. Throughput is one point per cycle: six arithmetic
//   stages (translate, rotate, shear, split products, merge products, sums)
//   feed two 20-stage dividers that resolve one quotient bit per stage, then
//   one output register.
//   The receiver cannot stall; words are shown once and dropped after.
//   Reset clears the pipeline valid bits and loads the default corners
//   (A=(0,0), B=(0,1023), C=(1023,1023), D=(1023,0)).
`include "quad_to_unit_square_point_map_unit_macros.svh"

module quad_to_unit_square_point_map_unit import q2us_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [COORD_BITS-1:0]   i_pt_x,
    input  logic [COORD_BITS-1:0]   i_pt_y,
    output logic                    o_valid,
    output logic signed [OUT_W-1:0] o_out_u,
    output logic signed [OUT_W-1:0] o_out_v,
    output logic                    o_degenerate,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [COORD_BITS-1:0]   i_cfg_data
);

    logic w_accept;
    logic w_cfg_we;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start & ~busy;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;

    // corner registers
    logic [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy, r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= COORD_MIN;
            r_ay <= COORD_MIN;
            r_bx <= COORD_MIN;
            r_by <= COORD_MAX;
            r_cx <= COORD_MAX;
            r_cy <= COORD_MAX;
            r_dx <= COORD_MAX;
            r_dy <= COORD_MIN;
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                CFG_A_X: r_ax <= i_cfg_data;
                CFG_A_Y: r_ay <= i_cfg_data;
                CFG_B_X: r_bx <= i_cfg_data;
                CFG_B_Y: r_by <= i_cfg_data;
                CFG_C_X: r_cx <= i_cfg_data;
                CFG_C_Y: r_cy <= i_cfg_data;
                CFG_D_X: r_dx <= i_cfg_data;
                CFG_D_Y: r_dy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits travel with the word
    logic [PIPE_LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_LAT-2:0], w_accept};
        end
    end

    // stage 1: translate by A
    logic signed [DIFF_W-1:0] r1_qx, r1_qy, r1_bx, r1_by, r1_cx, r1_cy, r1_dx, r1_dy;

    always_ff @(posedge i_clk) begin
        r1_qx <= $signed({1'b0, i_pt_x}) - $signed({1'b0, r_ax});
        r1_qy <= $signed({1'b0, i_pt_y}) - $signed({1'b0, r_ay});
        r1_bx <= $signed({1'b0, r_bx}) - $signed({1'b0, r_ax});
        r1_by <= $signed({1'b0, r_by}) - $signed({1'b0, r_ay});
        r1_cx <= $signed({1'b0, r_cx}) - $signed({1'b0, r_ax});
        r1_cy <= $signed({1'b0, r_cy}) - $signed({1'b0, r_ay});
        r1_dx <= $signed({1'b0, r_dx}) - $signed({1'b0, r_ax});
        r1_dy <= $signed({1'b0, r_dy}) - $signed({1'b0, r_ay});
    end

    // stage 2: rotate point and corners, scaled by |b|
    logic signed [ROT_W-1:0] r2_rpx, r2_rpy, r2_rcx, r2_rcy, r2_rdx, r2_rdy, r2_lsq;

    always_ff @(posedge i_clk) begin
        r2_rpx <= ROT_W'(r1_qx * r1_by) - ROT_W'(r1_qy * r1_bx);
        r2_rpy <= ROT_W'(r1_qy * r1_by) + ROT_W'(r1_qx * r1_bx);
        r2_rcx <= ROT_W'(r1_cx * r1_by) - ROT_W'(r1_cy * r1_bx);
        r2_rcy <= ROT_W'(r1_cy * r1_by) + ROT_W'(r1_cx * r1_bx);
        r2_rdx <= ROT_W'(r1_dx * r1_by) - ROT_W'(r1_dy * r1_bx);
        r2_rdy <= ROT_W'(r1_dy * r1_by) + ROT_W'(r1_dx * r1_bx);
        r2_lsq <= ROT_W'(r1_bx * r1_bx) + ROT_W'(r1_by * r1_by);
    end

    // stage 3: shear y by D's slope, kept as a multiple of rdx
    logic signed [SHR_W-1:0] r3_q, r3_cq, r3_ldx;
    logic signed [ROT_W-1:0] r3_rpx, r3_rcx, r3_rdx;
    logic                    r3_zero;

    always_ff @(posedge i_clk) begin
        r3_q    <= SHR_W'(r2_rpy * r2_rdx) - SHR_W'(r2_rpx * r2_rdy);
        r3_cq   <= SHR_W'(r2_rcy * r2_rdx) - SHR_W'(r2_rcx * r2_rdy);
        r3_ldx  <= SHR_W'(r2_lsq * r2_rdx);
        r3_rpx  <= r2_rpx;
        r3_rcx  <= r2_rcx;
        r3_rdx  <= r2_rdx;
        r3_zero <= (r2_rdx == '0) || (r2_rcx == '0);
    end

    // stage 4: split each wide product into two half-width partial products
    logic signed [ROT_W-1:0]   s4_a [NUM_PROD];
    logic signed [SHR_W-1:0]   s4_b [NUM_PROD];
    logic signed [PP_LO_W-1:0] r4_lo [NUM_PROD];
    logic signed [PP_HI_W-1:0] r4_hi [NUM_PROD];
    logic                      r4_deg;

    always_comb begin
        s4_a[0] = r3_rpx; s4_b[0] = r3_cq;   // u numerator
        s4_a[1] = r3_rcx; s4_b[1] = r3_q;    // v numerator
        s4_a[2] = r3_rdx; s4_b[2] = r3_q;
        s4_a[3] = r3_rdx; s4_b[3] = r3_cq;
        s4_a[4] = r3_rpx; s4_b[4] = r3_ldx;
        s4_a[5] = r3_rcx; s4_b[5] = r3_ldx;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_PROD; i++) begin
            r4_lo[i] <= PP_LO_W'(s4_a[i] * $signed({1'b0, s4_b[i][HALF_W-1:0]}));
            r4_hi[i] <= PP_HI_W'(s4_a[i] * $signed(s4_b[i][SHR_W-1:HALF_W]));
        end
        r4_deg <= r3_zero || (r3_cq == '0);
    end

    // stage 5: merge partial products
    logic signed [PROD_W-1:0] r5_p [NUM_PROD];
    logic                     r5_deg;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_PROD; i++) begin
            r5_p[i] <= (PROD_W'(r4_hi[i]) <<< HALF_W) + PROD_W'(r4_lo[i]);
        end
        r5_deg <= r4_deg;
    end

    // stage 6: numerators and edge-scale denominators
    logic signed [NUM_W-1:0] r6_nu, r6_du, r6_nv, r6_dv;
    logic                    r6_deg;

    always_ff @(posedge i_clk) begin
        r6_nu  <= r5_p[0];
        r6_nv  <= r5_p[1];
        r6_du  <= r5_p[1] - r5_p[2] + r5_p[3];
        r6_dv  <= r5_p[0] - r5_p[4] + r5_p[5];
        r6_deg <= r5_deg;
    end

    // carry the degenerate flag alongside the dividers
    logic [DIV_LAT-1:0] r_deg;

    always_ff @(posedge i_clk) begin
        r_deg <= {r_deg[DIV_LAT-2:0], r6_deg || (r6_du == '0) || (r6_dv == '0)};
    end

    logic signed [OUT_W-1:0] w_quo_u;
    logic signed [OUT_W-1:0] w_quo_v;

    q2us_div u_div_u (
        .i_clk (i_clk),
        .i_num (r6_nu),
        .i_den (r6_du),
        .o_quo (w_quo_u)
    );

    q2us_div u_div_v (
        .i_clk (i_clk),
        .i_num (r6_nv),
        .i_den (r6_dv),
        .o_quo (w_quo_v)
    );

    // output register: zero both coordinates on a degenerate word
    logic signed [OUT_W-1:0] r_out_u;
    logic signed [OUT_W-1:0] r_out_v;
    logic                    r_out_deg;

    always_ff @(posedge i_clk) begin
        r_out_u   <= r_deg[DIV_LAT-1] ? '0 : w_quo_u;
        r_out_v   <= r_deg[DIV_LAT-1] ? '0 : w_quo_v;
        r_out_deg <= r_deg[DIV_LAT-1];
    end

    assign o_valid      = r_vld[PIPE_LAT-1];
    assign o_out_u      = r_out_u;
    assign o_out_v      = r_out_v;
    assign o_degenerate = r_out_deg;

    // checks
    `Q2US_ASSERT_IMP(a_latency, w_accept, ##PIPE_LAT o_valid, "accepted word did not emerge")
    `Q2US_ASSERT_IMP(a_deg_zero, o_valid && o_degenerate, (o_out_u == '0) && (o_out_v == '0), "degenerate word not zeroed")
    `Q2US_ASSERT_IMP(a_cfg_idle, w_cfg_we, r_vld == '0, "corner write while words in flight")
    `Q2US_ASSERT_NXT(a_deg_flow, r6_deg, r_deg[0], "degenerate flag lost before divider")

endmodule
